### design/afc_pkg.sv
package afc_pkg;

    // Default sizes of the plane chain and the coordinate datapath.
    localparam int DEF_NUM_PLANES  = 6;
    localparam int DEF_COORD_WIDTH = 32;

    // Fixed port field widths.
    localparam int IDX_WIDTH    = 3;
    localparam int FIELD_WIDTH  = 32;
    localparam int EXT_WIDTH    = 31;
    localparam int FRAC_BITS    = 16;

    // Input tdata layout, lowest bit first.
    localparam int OFF_INDEX = 0;
    localparam int OFF_A     = OFF_INDEX + IDX_WIDTH;
    localparam int OFF_B     = OFF_A + FIELD_WIDTH;
    localparam int OFF_C     = OFF_B + FIELD_WIDTH;
    localparam int OFF_D     = OFF_C + FIELD_WIDTH;
    localparam int OFF_CX    = OFF_D + FIELD_WIDTH;
    localparam int OFF_CY    = OFF_CX + FIELD_WIDTH;
    localparam int OFF_CZ    = OFF_CY + FIELD_WIDTH;
    localparam int OFF_EX    = OFF_CZ + FIELD_WIDTH;
    localparam int OFF_EY    = OFF_EX + EXT_WIDTH;
    localparam int OFF_EZ    = OFF_EY + EXT_WIDTH;
    localparam int S_FIELDS_WIDTH = OFF_EZ + EXT_WIDTH;
    localparam int S_TDATA_WIDTH  = ((S_FIELDS_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH  = 8;

    // Item kinds carried in s_tuser.
    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_TEST = 1'b1;

    // Control that travels with every item along the plane chain.
    typedef struct packed {
        logic                 valid;
        logic                 is_test;
        logic [IDX_WIDTH-1:0] index;
        logic                 visible;
    } ctrl_t;

endpackage

### design/aabb_frustum_cull_unit.sv
// Channel  | Direction | Ports                          | Carries
// s_       | in        | s_tvalid s_tready s_tuser s_tdata | plane load or box test
// m_       | out       | m_tvalid m_tready m_tdata      | visibility of one tested box
//
// One item is taken every cycle while the chain is not halted; a test result passes
// the entry register, the two-stage cell for each plane in the chain, and the output register.
// Loads ride the chain in order, so each box sees exactly the planes loaded before it.
// Reset clears all stored planes to zero; the block is ready right after.
// While the output and skid registers are both full, the whole chain holds.
module aabb_frustum_cull_unit #(
    parameter int NUM_PLANES  = afc_pkg::DEF_NUM_PLANES,
    parameter int COORD_WIDTH = afc_pkg::DEF_COORD_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tuser: action (0 load, 1 test)
    input  logic                              s_tuser,
    // tdata: plane_index[2:0], plane_a, plane_b, plane_c, plane_d, center_x,
    // center_y, center_z, extent_x, extent_y, extent_z
    input  logic [afc_pkg::S_TDATA_WIDTH-1:0] s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata: visible, then zero fill
    output logic [afc_pkg::M_TDATA_WIDTH-1:0] m_tdata
);

    localparam int CW = COORD_WIDTH;

    afc_pkg::ctrl_t                       ctrl   [NUM_PLANES+1];
    logic [NUM_PLANES:0][3:0][CW-1:0]     plane;
    logic [NUM_PLANES:0][2:0][CW:0]       lo;
    logic [NUM_PLANES:0][2:0][CW:0]       hi;

    afc_pkg::ctrl_t           ctrl0_reg, ctrl0_next;
    logic [3:0][CW-1:0]       plane0_reg, plane0_next;
    logic [2:0][CW:0]         lo0_reg, lo0_next;
    logic [2:0][CW:0]         hi0_reg, hi0_next;

    logic                     en;
    logic                     res_valid;
    logic                     res_visible;

    // Unpack the transaction and form the low and high corner coordinates.
    always_comb begin
        logic [CW-1:0]   c;
        logic [CW-2:0]   e;
        ctrl0_next.valid   = s_tvalid;
        ctrl0_next.is_test = s_tuser;
        ctrl0_next.index   = s_tdata[afc_pkg::OFF_INDEX +: afc_pkg::IDX_WIDTH];
        ctrl0_next.visible = 1'b1;
        plane0_next[0] = s_tdata[afc_pkg::OFF_A +: CW];
        plane0_next[1] = s_tdata[afc_pkg::OFF_B +: CW];
        plane0_next[2] = s_tdata[afc_pkg::OFF_C +: CW];
        plane0_next[3] = s_tdata[afc_pkg::OFF_D +: CW];
        for (int k = 0; k < 3; k++) begin
            c = s_tdata[afc_pkg::OFF_CX + k * afc_pkg::FIELD_WIDTH +: CW];
            e = s_tdata[afc_pkg::OFF_EX + k * afc_pkg::EXT_WIDTH +: CW - 1];
            lo0_next[k] = {c[CW-1], c} - {2'b00, e};
            hi0_next[k] = {c[CW-1], c} + {2'b00, e};
        end
    end

    // Entry stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl0_reg <= '0;
        end else if (en) begin
            ctrl0_reg <= ctrl0_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            plane0_reg <= plane0_next;
            lo0_reg    <= lo0_next;
            hi0_reg    <= hi0_next;
        end
    end

    assign ctrl[0]  = ctrl0_reg;
    assign plane[0] = plane0_reg;
    assign lo[0]    = lo0_reg;
    assign hi[0]    = hi0_reg;

    // One cell per plane; every item passes through all of them in order.
    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_cell
        afc_cell #(
            .CELL_INDEX  (p),
            .COORD_WIDTH (CW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_ctrl   (ctrl[p]),
            .in_plane  (plane[p]),
            .in_lo     (lo[p]),
            .in_hi     (hi[p]),
            .out_ctrl  (ctrl[p+1]),
            .out_plane (plane[p+1]),
            .out_lo    (lo[p+1]),
            .out_hi    (hi[p+1])
        );
    end

    // Only test items leave the chain as results.
    assign res_valid   = ctrl[NUM_PLANES].valid
                         && (ctrl[NUM_PLANES].is_test == afc_pkg::ACTION_TEST);
    assign res_visible = ctrl[NUM_PLANES].visible;

    afc_out_skid u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (res_valid),
        .in_visible  (res_visible),
        .in_ready    (en),
        .out_valid   (m_tvalid),
        .out_visible (m_tdata[0]),
        .out_ready   (m_tready)
    );

    assign s_tready = en;
    assign m_tdata[afc_pkg::M_TDATA_WIDTH-1:1] = '0;

endmodule

### design/afc_cell.sv
module afc_cell #(
    parameter int CELL_INDEX  = 0,
    parameter int COORD_WIDTH = afc_pkg::DEF_COORD_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  afc_pkg::ctrl_t                in_ctrl,
    input  logic [3:0][COORD_WIDTH-1:0]   in_plane,
    input  logic [2:0][COORD_WIDTH:0]     in_lo,
    input  logic [2:0][COORD_WIDTH:0]     in_hi,
    output afc_pkg::ctrl_t                out_ctrl,
    output logic [3:0][COORD_WIDTH-1:0]   out_plane,
    output logic [2:0][COORD_WIDTH:0]     out_lo,
    output logic [2:0][COORD_WIDTH:0]     out_hi
);

    localparam int IW = afc_pkg::IDX_WIDTH;
    localparam logic [IW-1:0] MY_INDEX = IW'(CELL_INDEX);
    localparam int PW = 2 * COORD_WIDTH + 1;
    localparam int SW = PW + 2;
    localparam int DPAD = SW - afc_pkg::FRAC_BITS - COORD_WIDTH;

    // Plane held by this cell: a, b, c, d.
    logic [3:0][COORD_WIDTH-1:0] coef_reg, coef_next;

    // First stage: products of the coefficients with the far corner.
    afc_pkg::ctrl_t              s1_ctrl_reg;
    logic [3:0][COORD_WIDTH-1:0] s1_plane_reg;
    logic [2:0][COORD_WIDTH:0]   s1_lo_reg, s1_hi_reg;
    logic [2:0][PW-1:0]          s1_prod_reg, s1_prod_next;
    logic [COORD_WIDTH-1:0]      s1_d_reg;

    // Second stage: distance sign and the running visibility flag.
    afc_pkg::ctrl_t              out_ctrl_reg, out_ctrl_next;
    logic [3:0][COORD_WIDTH-1:0] out_plane_reg;
    logic [2:0][COORD_WIDTH:0]   out_lo_reg, out_hi_reg;

    logic                        write_hit;
    logic signed [SW-1:0]        plane_dist;
    logic                        in_front;

    // A load item whose index names this cell replaces the stored plane.
    assign write_hit = in_ctrl.valid && (in_ctrl.is_test == afc_pkg::ACTION_TEST ? 1'b0 : 1'b1)
                       && (in_ctrl.index == MY_INDEX);
    assign coef_next = write_hit ? in_plane : coef_reg;

    // For each axis, pick the corner coordinate that maximizes the distance:
    // the high side for a non-negative coefficient, the low side otherwise.
    always_comb begin
        logic [COORD_WIDTH:0] corner;
        for (int k = 0; k < 3; k++) begin
            corner = coef_reg[k][COORD_WIDTH-1] ? in_lo[k] : in_hi[k];
            s1_prod_next[k] = PW'($signed(coef_reg[k]) * $signed(corner));
        end
    end

    // The largest distance over all corners is positive exactly when some
    // corner lies strictly in front of the plane.
    assign plane_dist = $signed({{2{s1_prod_reg[0][PW-1]}}, s1_prod_reg[0]})
                      + $signed({{2{s1_prod_reg[1][PW-1]}}, s1_prod_reg[1]})
                      + $signed({{2{s1_prod_reg[2][PW-1]}}, s1_prod_reg[2]})
                      + $signed({{DPAD{s1_d_reg[COORD_WIDTH-1]}}, s1_d_reg,
                                 {afc_pkg::FRAC_BITS{1'b0}}});
    assign in_front = !plane_dist[SW-1] && (plane_dist != '0);

    always_comb begin
        out_ctrl_next = s1_ctrl_reg;
        if (s1_ctrl_reg.is_test == afc_pkg::ACTION_TEST) begin
            out_ctrl_next.visible = s1_ctrl_reg.visible && in_front;
        end
    end

    // Control and plane store.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg     <= '0;
            s1_ctrl_reg  <= '0;
            out_ctrl_reg <= '0;
        end else if (en) begin
            coef_reg     <= coef_next;
            s1_ctrl_reg  <= in_ctrl;
            out_ctrl_reg <= out_ctrl_next;
        end
    end

    // Payload stages.
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_plane_reg  <= in_plane;
            s1_lo_reg     <= in_lo;
            s1_hi_reg     <= in_hi;
            s1_prod_reg   <= s1_prod_next;
            s1_d_reg      <= coef_reg[3];
            out_plane_reg <= s1_plane_reg;
            out_lo_reg    <= s1_lo_reg;
            out_hi_reg    <= s1_hi_reg;
        end
    end

    assign out_ctrl  = out_ctrl_reg;
    assign out_plane = out_plane_reg;
    assign out_lo    = out_lo_reg;
    assign out_hi    = out_hi_reg;

endmodule

### design/afc_out_skid.sv
module afc_out_skid (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    input  logic in_visible,
    output logic in_ready,
    output logic out_valid,
    output logic out_visible,
    input  logic out_ready
);

    logic out_valid_reg, out_valid_next;
    logic out_data_reg, out_data_next;
    logic skid_valid_reg, skid_valid_next;
    logic skid_data_reg, skid_data_next;
    logic take;

    assign take = out_valid_reg && out_ready;

    // A result goes to the output register when it is free or being taken,
    // and to the skid register otherwise; the chain halts while that is full.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (take) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_valid) begin
            if (!out_valid_reg || take) begin
                out_valid_next = 1'b1;
                out_data_next  = in_visible;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_visible;
            end
        end else if (take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready    = !skid_valid_reg;
    assign out_valid   = out_valid_reg;
    assign out_visible = out_data_reg;

endmodule

### design/afc_checker.sv
module afc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [afc_pkg::M_TDATA_WIDTH-1:0] m_tdata
);

    // A stalled result stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // Only the visible flag is ever set in the result word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[afc_pkg::M_TDATA_WIDTH-1:1] == '0)
        else $error("fill bits of the result word are set");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // The input side is open again right after reset.
    assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

endmodule

bind aabb_frustum_cull_unit afc_checker u_afc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### bench/tb_aabb_frustum_cull_unit.sv
module tb_aabb_frustum_cull_unit;

    localparam int PLANE_COUNT = afc_pkg::DEF_NUM_PLANES;
    localparam int CHAIN_LATENCY = 2 * PLANE_COUNT + 2;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 950;
    localparam int STREAM_ITEMS = 150;
    localparam int IDX_BITS = afc_pkg::IDX_WIDTH;

    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic [30:0] EXT_MAX = 31'h7fff_ffff;

    // How a random scene picks its planes and boxes.
    typedef enum int {
        STYLE_AXIS,
        STYLE_SMALL,
        STYLE_WIDE,
        STYLE_EXTREME_BOX
    } scene_style_t;

    typedef struct {
        logic                              action;
        logic [afc_pkg::IDX_WIDTH-1:0]     idx;
        logic signed [31:0]                pa, pb, pc, pd;
        logic signed [31:0]                cx, cy, cz;
        logic [afc_pkg::EXT_WIDTH-1:0]     ex, ey, ez;
    } cull_item_t;

    typedef struct {
        logic signed [31:0] a, b, c, d;
    } plane_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_tvalid;
    logic                              s_tready;
    // tuser: action (0 load, 1 test)
    logic                              s_tuser;
    // tdata: plane_index, plane_a, plane_b, plane_c, plane_d, center_x, center_y,
    // center_z, extent_x, extent_y, extent_z
    logic [afc_pkg::S_TDATA_WIDTH-1:0] s_tdata;
    logic                              m_tvalid;
    logic                              m_tready;
    // tdata: visible, then zero fill
    logic [afc_pkg::M_TDATA_WIDTH-1:0] m_tdata;

    plane_t tb_planes[PLANE_COUNT];
    bit     expected_visibility[$];
    bit     traffic_gaps;
    int     items_sent;
    int     planes_loaded;
    int     boxes_tested;
    int     boxes_visible;
    int     errors;
    int     cycle_count;

    aabb_frustum_cull_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock with a period of two time units.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Exact visibility of one box against the current plane set. All sums are
    // carried at 128 bits, so no term can overflow.
    function automatic bit predict_visible(input cull_item_t it);
        logic signed [127:0] cx, cy, cz, ex, ey, ez;
        logic signed [127:0] x, y, z, pa, pb, pc, pd, plane_dist;
        bit any_front;
        bit seen;
        seen = 1'b1;
        cx = it.cx;
        cy = it.cy;
        cz = it.cz;
        ex = it.ex;
        ey = it.ey;
        ez = it.ez;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            pa = tb_planes[p].a;
            pb = tb_planes[p].b;
            pc = tb_planes[p].c;
            pd = tb_planes[p].d;
            any_front = 1'b0;
            for (int k = 0; k < 8; k++) begin
                x = ((k & 1) != 0) ? cx + ex : cx - ex;
                y = ((k & 2) != 0) ? cy + ey : cy - ey;
                z = ((k & 4) != 0) ? cz + ez : cz - ez;
                plane_dist = pa * x + pb * y + pc * z + (pd <<< afc_pkg::FRAC_BITS);
                if (plane_dist > 0)
                    any_front = 1'b1;
            end
            if (!any_front)
                seen = 1'b0;
        end
        return seen;
    endfunction

    // Send one item, with an optional idle burst first, and record it once
    // the transaction completes.
    task automatic send_item(input cull_item_t it);
        logic [afc_pkg::S_TDATA_WIDTH-1:0] word;
        bit seen;
        word = '0;
        word[afc_pkg::OFF_INDEX +: afc_pkg::IDX_WIDTH] = it.idx;
        word[afc_pkg::OFF_A  +: afc_pkg::FIELD_WIDTH] = it.pa;
        word[afc_pkg::OFF_B  +: afc_pkg::FIELD_WIDTH] = it.pb;
        word[afc_pkg::OFF_C  +: afc_pkg::FIELD_WIDTH] = it.pc;
        word[afc_pkg::OFF_D  +: afc_pkg::FIELD_WIDTH] = it.pd;
        word[afc_pkg::OFF_CX +: afc_pkg::FIELD_WIDTH] = it.cx;
        word[afc_pkg::OFF_CY +: afc_pkg::FIELD_WIDTH] = it.cy;
        word[afc_pkg::OFF_CZ +: afc_pkg::FIELD_WIDTH] = it.cz;
        word[afc_pkg::OFF_EX +: afc_pkg::EXT_WIDTH]   = it.ex;
        word[afc_pkg::OFF_EY +: afc_pkg::EXT_WIDTH]   = it.ey;
        word[afc_pkg::OFF_EZ +: afc_pkg::EXT_WIDTH]   = it.ez;
        if (traffic_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.action;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        items_sent++;

        // Update the local plane copy or queue the expected visibility.
        if (it.action == afc_pkg::ACTION_LOAD) begin
            planes_loaded++;
            if (it.idx < PLANE_COUNT)
                tb_planes[it.idx] = '{it.pa, it.pb, it.pc, it.pd};
        end else begin
            seen = predict_visible(it);
            expected_visibility.push_back(seen);
            boxes_tested++;
            if (seen)
                boxes_visible++;
        end
    endtask

    // A plane load; the box fields carry random filler.
    task automatic load_plane(input int idx, input logic signed [31:0] a, b, c, d);
        cull_item_t it;
        it.action = afc_pkg::ACTION_LOAD;
        it.idx = idx[afc_pkg::IDX_WIDTH-1:0];
        it.pa = a;
        it.pb = b;
        it.pc = c;
        it.pd = d;
        it.cx = $urandom();
        it.cy = $urandom();
        it.cz = $urandom();
        it.ex = 31'($urandom());
        it.ey = 31'($urandom());
        it.ez = 31'($urandom());
        send_item(it);
    endtask

    // A box test; the plane fields carry random filler.
    task automatic test_box(input logic signed [31:0] cx, cy, cz,
                            input logic [afc_pkg::EXT_WIDTH-1:0] ex, ey, ez);
        cull_item_t it;
        it.action = afc_pkg::ACTION_TEST;
        it.idx = IDX_BITS'($urandom_range(0, 7));
        it.pa = $urandom();
        it.pb = $urandom();
        it.pc = $urandom();
        it.pd = $urandom();
        it.cx = cx;
        it.cy = cy;
        it.cz = cz;
        it.ex = ex;
        it.ey = ey;
        it.ez = ez;
        send_item(it);
    endtask

    // Random Q16.16 value within plus or minus whole units, with a fraction.
    function automatic logic signed [31:0] rand_q16(input int whole);
        return int'($urandom_range(0, 2 * whole * 65536)) - whole * 65536;
    endfunction

    // Random whole number of units within plus or minus whole.
    function automatic logic signed [31:0] rand_int_q16(input int whole);
        return (int'($urandom_range(0, 2 * whole)) - whole) * 65536;
    endfunction

    // A coordinate that is often at one of the range limits.
    function automatic logic signed [31:0] rand_edge_coord();
        case ($urandom_range(0, 3))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return '0;
            default: return $urandom();
        endcase
    endfunction

    task automatic load_random_plane(input int idx, input scene_style_t style);
        logic signed [31:0] coef[3];
        logic signed [31:0] offs;
        int axis;
        case (style)
            STYLE_AXIS: begin
                coef = '{0, 0, 0};
                axis = $urandom_range(0, 2);
                coef[axis] = $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
                offs = rand_int_q16(20);
            end
            STYLE_WIDE: begin
                coef = '{$urandom(), $urandom(), $urandom()};
                offs = $urandom();
            end
            default: begin
                coef = '{rand_q16(2), rand_q16(2), rand_q16(2)};
                offs = rand_q16(50);
            end
        endcase
        load_plane(idx, coef[0], coef[1], coef[2], offs);
    endtask

    task automatic test_random_box(input scene_style_t style);
        case (style)
            STYLE_AXIS:
                test_box(rand_int_q16(30), rand_int_q16(30), rand_int_q16(30),
                         31'($urandom_range(0, 15) * 65536),
                         31'($urandom_range(0, 15) * 65536),
                         31'($urandom_range(0, 15) * 65536));
            STYLE_SMALL:
                test_box(rand_q16(80), rand_q16(80), rand_q16(80),
                         31'($urandom_range(0, 40 * 65536)),
                         31'($urandom_range(0, 40 * 65536)),
                         31'($urandom_range(0, 40 * 65536)));
            STYLE_WIDE:
                test_box($urandom(), $urandom(), $urandom(),
                         31'($urandom() >> 1), 31'($urandom() >> 1),
                         31'($urandom() >> 1));
            default:
                test_box(rand_edge_coord(), rand_edge_coord(), rand_edge_coord(),
                         $urandom_range(0, 1) ? EXT_MAX : 31'($urandom() >> 1),
                         $urandom_range(0, 2) == 0 ? 31'd0 : 31'($urandom() >> 1),
                         $urandom_range(0, 1) ? EXT_MAX : 31'd0);
        endcase
    endtask

    // Before any load every plane is all zero, so every distance is zero.
    task automatic test_unloaded_store();
        test_box('0, '0, '0, 31'd65536, 31'd65536, 31'd65536);
    endtask

    // A cube of half-size ten around the origin, with boxes inside, outside,
    // exactly touching a face and just across it.
    task automatic test_unit_cube_frustum();
        load_plane(0,  Q_ONE, '0, '0, 10 * Q_ONE);
        load_plane(1, -Q_ONE, '0, '0, 10 * Q_ONE);
        load_plane(2, '0,  Q_ONE, '0, 10 * Q_ONE);
        load_plane(3, '0, -Q_ONE, '0, 10 * Q_ONE);
        load_plane(4, '0, '0,  Q_ONE, 10 * Q_ONE);
        load_plane(5, '0, '0, -Q_ONE, 10 * Q_ONE);
        test_box('0, '0, '0, 31'd65536, 31'd65536, 31'd65536);
        test_box(50 * Q_ONE, '0, '0, 31'd65536, 31'd65536, 31'd65536);
        // Nearest corner lies exactly on the face, which counts as behind.
        test_box(20 * Q_ONE, '0, '0, 31'(10 * 65536), 31'd0, 31'd0);
        // One step further and the nearest corner is in front.
        test_box(20 * Q_ONE, '0, '0, 31'(10 * 65536 + 1), 31'd0, 31'd0);
        test_box('0, '0, '0, 31'(1000 * 65536), 31'(1000 * 65536), 31'(1000 * 65536));
        test_box(10 * Q_ONE, '0, '0, 31'd0, 31'd0, 31'd0);
    endtask

    // Loads to slots past the last plane must leave the store untouched.
    task automatic test_ignored_indexes();
        load_plane(6, '0, '0, '0, '0);
        load_plane(7, '0, '0, '0, '0);
        test_box('0, '0, '0, 31'd0, 31'd0, 31'd0);
    endtask

    // Coefficients, centres and extents at their range limits, then a plane
    // cleared back to zero.
    task automatic test_extreme_values();
        load_plane(0, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        test_box(Q_MAX, Q_MAX, Q_MAX, 31'd0, 31'd0, 31'd0);
        test_box(Q_MIN, Q_MIN, Q_MIN, EXT_MAX, EXT_MAX, EXT_MAX);
        load_plane(1, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        test_box(Q_MAX, Q_MAX, Q_MAX, EXT_MAX, EXT_MAX, EXT_MAX);
        test_box(Q_MIN, Q_MAX, Q_MIN, 31'd0, EXT_MAX, 31'd0);
        load_plane(5, '0, '0, '0, '0);
        test_box('0, '0, '0, EXT_MAX, EXT_MAX, EXT_MAX);
    endtask

    // Random scenes: a fresh plane set, some stray loads, then a run of boxes.
    task automatic test_random_frustums(input int item_count);
        scene_style_t style;
        int stop_at;
        stop_at = items_sent + item_count;
        while (items_sent < stop_at) begin
            style = scene_style_t'($urandom_range(0, 3));
            for (int p = 0; p < PLANE_COUNT; p++) begin
                if ($urandom_range(0, 5) != 0)
                    load_random_plane(p, style);
            end
            if ($urandom_range(0, 3) == 0)
                load_random_plane($urandom_range(0, 7), STYLE_WIDE);
            repeat ($urandom_range(5, 30)) begin
                if ($urandom_range(0, 19) == 0)
                    load_random_plane($urandom_range(0, 7), style);
                test_random_box(style);
            end
        end
    endtask

    // Closing stretch with no idle cycles on either side.
    task automatic test_back_to_back(input int item_count);
        traffic_gaps = 1'b0;
        test_random_frustums(item_count);
    endtask

    // Result sink: random backpressure bursts while gaps are enabled.
    initial begin
        @(posedge aclk);
        forever begin
            if (traffic_gaps && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // Compare every result transaction with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_visibility.size() == 0) begin
                if (errors < 10)
                    $display("Unexpected result: visible=%0b", m_tdata[0]);
                errors++;
            end else if (m_tdata[0] !== expected_visibility[0]) begin
                if (errors < 10)
                    $display("Visibility mismatch: expected %0b, got %0b",
                             expected_visibility[0], m_tdata[0]);
                errors++;
                void'(expected_visibility.pop_front());
            end else begin
                void'(expected_visibility.pop_front());
            end
        end
    end

    // Watchdog on the total cycle count.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("RESULT: ERROR");
        $finish;
    end

    // Main sequence.
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = afc_pkg::ACTION_LOAD;
        s_tdata  = '0;
        m_tready = 1'b0;
        traffic_gaps = 1'b1;
        items_sent = 0;
        planes_loaded = 0;
        boxes_tested = 0;
        boxes_visible = 0;
        errors = 0;
        foreach (tb_planes[p])
            tb_planes[p] = '{'0, '0, '0, '0};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unloaded_store();
        test_unit_cube_frustum();
        test_ignored_indexes();
        test_extreme_values();
        test_random_frustums(RANDOM_ITEMS);
        test_back_to_back(STREAM_ITEMS);

        // Let the chain drain, then keep watching for strays before the final check.
        s_tvalid <= 1'b0;
        while (expected_visibility.size() != 0) @(posedge aclk);
        repeat (CHAIN_LATENCY + 8) @(posedge aclk);
        if (expected_visibility.size() != 0)
            errors++;

        $display("Sent %0d plane loads and %0d box tests over %0d cycles.",
                 planes_loaded, boxes_tested, cycle_count);
        $display("Of the boxes, %0d were visible and %0d culled; %0d mismatches.",
                 boxes_visible, boxes_tested - boxes_visible, errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
